// ===== rtl/faa_pkg.sv =====
// ----------------------------------------------------------------------------
// faa_pkg: shared types and constants of the frame address auto-increment unit
// Word layouts of both channels, function codes, register indexes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package faa_pkg;

    // Default table geometry
    localparam int MAX_ROWS_DEF    = 16;
    localparam int MAX_COLUMNS_DEF = 256;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int TROW_W  = 4;
    localparam int TCOL_W  = 8;
    localparam int CNT_W   = 9;
    localparam int WORD_W  = 27;
    localparam int TYPE_W  = 3;
    localparam int RROW_W  = 6;
    localparam int COL_W   = 10;
    localparam int MINOR_W = 8;
    localparam int REGROW_W = 4;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd2;

    // Block types that advance
    localparam logic [TYPE_W-1:0] TYPE_LOGIC = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_BRAM  = 3'd1;

    // Register indexes
    localparam logic [2:0] REG_LOGIC_COLUMNS = 3'd0;
    localparam logic [2:0] REG_BRAM_COLUMNS  = 3'd1;
    localparam logic [2:0] REG_FIRST_ROW     = 3'd2;
    localparam logic [2:0] REG_LAST_ROW      = 3'd3;
    localparam logic [2:0] REG_EXTRA_FRAMES  = 3'd4;
    localparam logic [2:0] REG_BRAM_FRAMES   = 3'd5;

    // Register reset values
    localparam logic [CNT_W-1:0]    RST_LOGIC_COLUMNS = 9'd128;
    localparam logic [CNT_W-1:0]    RST_BRAM_COLUMNS  = 9'd16;
    localparam logic [REGROW_W-1:0] RST_FIRST_ROW     = 4'd0;
    localparam logic [REGROW_W-1:0] RST_LAST_ROW      = 4'd15;
    localparam logic [CNT_W-1:0]    RST_EXTRA_FRAMES  = 9'd2;
    localparam logic [CNT_W-1:0]    RST_BRAM_FRAMES   = 9'd256;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TROW_W-1:0] table_row;
        logic [TCOL_W-1:0] table_column;
        logic [CNT_W-1:0]  frame_count;
        logic [WORD_W-1:0] address_word;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]   current_word;
        logic [TYPE_W-1:0]   block_type;
        logic [REGROW_W-1:0] row;
        logic [COL_W-1:0]    column;
        logic [MINOR_W-1:0]  minor;
        logic                row_overflow;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]    logic_columns;
        logic [CNT_W-1:0]    bram_columns;
        logic [REGROW_W-1:0] first_row;
        logic [REGROW_W-1:0] last_row;
        logic [CNT_W-1:0]    extra_frames;
        logic [CNT_W-1:0]    bram_frames;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/faa_ram.sv =====
// ----------------------------------------------------------------------------
// faa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module faa_ram #(
    parameter int WIDTH  = 9,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/faa_ctrl.sv =====
// ----------------------------------------------------------------------------
// faa_ctrl: sequencing of one word at a time
// Take a word in IDLE, finish it in EXEC once the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module faa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  faa_pkg::t_dp_status i_status,
    output faa_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   capture;
    logic   commit;

    // Handshake and commands
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        capture    = (r_state == S_IDLE) && i_in_valid;
        commit     = (r_state == S_EXEC) && i_status.out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.capture = capture;
    assign o_cmd.commit  = commit;

endmodule

// ===== rtl/faa_dp.sv =====
// ----------------------------------------------------------------------------
// faa_dp: frame address datapath
// Holds the address registers, the column frame table and the output register,
// and works out the next address for set, advance and table load words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module faa_dp #(
    parameter int MAX_ROWS    = faa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = faa_pkg::MAX_COLUMNS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  faa_pkg::t_cfg       i_cfg,
    input  faa_pkg::t_in_item   i_in_item,
    input  faa_pkg::t_ctrl_cmd  i_cmd,
    output faa_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output faa_pkg::t_out_item  o_out_item
);

    localparam int ROW_W   = ($clog2(MAX_ROWS) > 4) ? $clog2(MAX_ROWS) : 4;
    localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RECIP   = 4096 / MAX_ROWS;
    localparam int SUM_W   = faa_pkg::RROW_W + 1;
    localparam int IDX_W   = faa_pkg::COL_W + 1;

    // Row value modulo MAX_ROWS: reciprocal estimate, then one correction
    function automatic logic [ROW_W-1:0] mod_rows(input logic [SUM_W-1:0] v);
        logic [19:0]      prod;
        logic [SUM_W-1:0] q;
        logic [13:0]      qn;
        logic [SUM_W-1:0] rem;
        prod = 20'(v) * 20'(RECIP);
        q    = prod[18:12];
        qn   = 14'(q) * 14'(MAX_ROWS);
        rem  = v - qn[SUM_W-1:0];
        if (rem >= SUM_W'(MAX_ROWS)) begin
            rem = rem - SUM_W'(MAX_ROWS);
        end
        return rem[ROW_W-1:0];
    endfunction

    faa_pkg::t_in_item  r_item;
    logic [faa_pkg::TYPE_W-1:0]  r_type;
    logic [ROW_W-1:0]            r_row;
    logic [faa_pkg::COL_W-1:0]   r_column;
    logic [faa_pkg::MINOR_W-1:0] r_minor;
    logic [faa_pkg::TYPE_W-1:0]  n_type;
    logic [ROW_W-1:0]            n_row;
    logic [faa_pkg::COL_W-1:0]   n_column;
    logic [faa_pkg::MINOR_W-1:0] n_minor;
    logic                        n_overflow;
    logic                        r_out_valid;
    faa_pkg::t_out_item          r_out_item;
    faa_pkg::t_out_item          n_out_item;

    logic [ADDR_W-1:0]           raddr;
    logic [ADDR_W-1:0]           waddr;
    logic                        we;
    logic [faa_pkg::CNT_W-1:0]   rdata;

    logic [faa_pkg::CNT_W-1:0]   cols;
    logic [faa_pkg::CNT_W-1:0]   lim;
    logic [faa_pkg::MINOR_W-1:0] minor_inc;
    logic [faa_pkg::COL_W-1:0]   column_inc;
    logic [faa_pkg::COL_W-1:0]   cols_end;
    logic [ROW_W:0]              row_inc;
    logic [ROW_W-1:0]            row_first;
    logic [SUM_W-1:0]            set_row;
    logic                        col_in_table;
    logic                        load_in_table;
    logic [faa_pkg::RROW_W-1:0]  rel_row;

    // Column frame table
    assign col_in_table  = IDX_W'(r_column) < IDX_W'(MAX_COLUMNS);
    assign load_in_table = (SUM_W'(r_item.table_row) < SUM_W'(MAX_ROWS)) &&
                           (IDX_W'(r_item.table_column) < IDX_W'(MAX_COLUMNS));
    assign raddr = ADDR_W'(32'(r_row) * 32'(MAX_COLUMNS) + 32'(r_column));
    assign waddr = ADDR_W'(32'(r_item.table_row) * 32'(MAX_COLUMNS) +
                           32'(r_item.table_column));
    assign we    = i_cmd.commit && (r_item.func == faa_pkg::FUNC_LOAD) && load_in_table;

    faa_ram #(
        .WIDTH  (faa_pkg::CNT_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_item.frame_count),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Frame limit of the current column
    always_comb begin
        cols = (r_type == faa_pkg::TYPE_LOGIC) ? i_cfg.logic_columns : i_cfg.bram_columns;
        if (r_column == faa_pkg::COL_W'(cols)) begin
            lim = i_cfg.extra_frames;
        end else if (r_type == faa_pkg::TYPE_LOGIC) begin
            lim = col_in_table ? rdata : '0;
        end else begin
            lim = i_cfg.bram_frames;
        end
    end

    // Next address
    always_comb begin
        minor_inc  = r_minor + 1'b1;
        column_inc = r_column + 1'b1;
        cols_end   = faa_pkg::COL_W'(cols) + 1'b1;
        row_inc    = {1'b0, r_row} + 1'b1;
        row_first  = mod_rows(SUM_W'(i_cfg.first_row));
        set_row    = SUM_W'(r_item.address_word[23:18]) + SUM_W'(i_cfg.first_row);

        n_type     = r_type;
        n_row      = r_row;
        n_column   = r_column;
        n_minor    = r_minor;
        n_overflow = 1'b0;

        unique case (r_item.func)
            faa_pkg::FUNC_SET: begin
                n_type     = r_item.address_word[26:24];
                n_overflow = set_row >= SUM_W'(MAX_ROWS);
                n_row      = mod_rows(set_row);
                n_column   = r_item.address_word[17:8];
                n_minor    = r_item.address_word[7:0];
            end
            faa_pkg::FUNC_STEP: begin
                if (r_type == faa_pkg::TYPE_LOGIC || r_type == faa_pkg::TYPE_BRAM) begin
                    if (minor_inc != lim[faa_pkg::MINOR_W-1:0]) begin
                        n_minor = minor_inc;
                    end else begin
                        n_minor = '0;
                        if (column_inc != cols_end) begin
                            n_column = column_inc;
                        end else begin
                            n_column = '0;
                            if (r_row == ROW_W'(i_cfg.last_row)) begin
                                n_row  = row_first;
                                n_type = r_type + 1'b1;
                            end else if (row_inc == (ROW_W + 1)'(MAX_ROWS)) begin
                                n_row = '0;
                            end else begin
                                n_row = row_inc[ROW_W-1:0];
                            end
                        end
                    end
                end
            end
            default: begin
                // load and unused code keep the address
            end
        endcase
    end

    // Pack the result
    always_comb begin
        rel_row = faa_pkg::RROW_W'(n_row) - faa_pkg::RROW_W'(i_cfg.first_row);
        n_out_item.current_word = {n_type, rel_row, n_column, n_minor};
        n_out_item.block_type   = n_type;
        n_out_item.row          = n_row[faa_pkg::REGROW_W-1:0];
        n_out_item.column       = n_column;
        n_out_item.minor        = n_minor;
        n_out_item.row_overflow = n_overflow;
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
    end

    // Address registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type   <= '0;
            r_row    <= '0;
            r_column <= '0;
            r_minor  <= '0;
        end else if (i_cmd.commit) begin
            r_type   <= n_type;
            r_row    <= n_row;
            r_column <= n_column;
            r_minor  <= n_minor;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

endmodule

// ===== rtl/frame_address_autoincrement.sv =====
// ----------------------------------------------------------------------------
// frame_address_autoincrement: configuration frame address auto-increment
// Keeps a frame address (type, row, column, minor) and answers every input
// word with one result word holding the address after that word.
// Input channel i_in_valid/o_in_ready carries load, set or advance words;
// output channel o_out_valid/i_out_ready carries the result words.
// Each word is captured in IDLE while the column frame table read is issued
// at the current address; in EXEC it updates the address and loads the
// output register once that is free, and o_out_valid is set by that commit.
// A new word is not accepted until the previous one has been committed.
// A held result does not block the next input word; that word waits in its
// update cycle until the output register is taken.
// Reset clears the address to zero and returns registers to their defaults;
// the column frame table is not cleared and must be loaded before use.
// Users write registers over the APB-style port only while idle; not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_address_autoincrement #(
    parameter int MAX_ROWS    = faa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = faa_pkg::MAX_COLUMNS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  faa_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output faa_pkg::t_out_item              o_out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [faa_pkg::PADDR_W-1:0]     paddr,
    input  logic [faa_pkg::PDATA_W-1:0]     pwdata,
    output logic [faa_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    faa_pkg::t_cfg       r_cfg;
    faa_pkg::t_ctrl_cmd  cmd;
    faa_pkg::t_dp_status status;
    logic                cfg_wr;
    logic [2:0]          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.logic_columns <= faa_pkg::RST_LOGIC_COLUMNS;
            r_cfg.bram_columns  <= faa_pkg::RST_BRAM_COLUMNS;
            r_cfg.first_row     <= faa_pkg::RST_FIRST_ROW;
            r_cfg.last_row      <= faa_pkg::RST_LAST_ROW;
            r_cfg.extra_frames  <= faa_pkg::RST_EXTRA_FRAMES;
            r_cfg.bram_frames   <= faa_pkg::RST_BRAM_FRAMES;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                faa_pkg::REG_LOGIC_COLUMNS: r_cfg.logic_columns <= pwdata[8:0];
                faa_pkg::REG_BRAM_COLUMNS:  r_cfg.bram_columns  <= pwdata[8:0];
                faa_pkg::REG_FIRST_ROW:     r_cfg.first_row     <= pwdata[3:0];
                faa_pkg::REG_LAST_ROW:      r_cfg.last_row      <= pwdata[3:0];
                faa_pkg::REG_EXTRA_FRAMES:  r_cfg.extra_frames  <= pwdata[8:0];
                faa_pkg::REG_BRAM_FRAMES:   r_cfg.bram_frames   <= pwdata[8:0];
                default: begin
                    // drop writes to unused addresses
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (cfg_idx)
            faa_pkg::REG_LOGIC_COLUMNS: prdata = faa_pkg::PDATA_W'(r_cfg.logic_columns);
            faa_pkg::REG_BRAM_COLUMNS:  prdata = faa_pkg::PDATA_W'(r_cfg.bram_columns);
            faa_pkg::REG_FIRST_ROW:     prdata = faa_pkg::PDATA_W'(r_cfg.first_row);
            faa_pkg::REG_LAST_ROW:      prdata = faa_pkg::PDATA_W'(r_cfg.last_row);
            faa_pkg::REG_EXTRA_FRAMES:  prdata = faa_pkg::PDATA_W'(r_cfg.extra_frames);
            faa_pkg::REG_BRAM_FRAMES:   prdata = faa_pkg::PDATA_W'(r_cfg.bram_frames);
            default:                    prdata = '0;
        endcase
    end

    faa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    faa_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    // One word in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input word accepted while another is in work");

    // A new result follows the update cycle of an accepted word
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a word in work");

    // Reported row stays inside the row table
    a_row_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_item.row) < MAX_ROWS))
        else $error("reported row outside the row table");
`endif

endmodule
